FILE: rtl/smrb_pkg.sv
package smrb_pkg;

  // Register offsets
  localparam logic [9:0] OFF_CTRL1  = 10'h000;
  localparam logic [9:0] OFF_CTRL2  = 10'h004;
  localparam logic [9:0] OFF_STATUS = 10'h008;
  localparam logic [9:0] OFF_DATA   = 10'h00C;

  // Access kinds
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // Valid access sizes in bytes
  localparam logic [2:0] SIZE_BYTE = 3'd1;
  localparam logic [2:0] SIZE_HALF = 3'd2;
  localparam logic [2:0] SIZE_WORD = 3'd4;

  // Control one bits
  localparam int ENABLE_BIT = 6;
  localparam int WIDE_BIT   = 11;
  // Control two bits
  localparam int RX_IE_BIT  = 6;
  localparam int TX_IE_BIT  = 7;
  // Status flag bits
  localparam int FLAG_RX_FULL  = 0;
  localparam int FLAG_TX_EMPTY = 1;

  localparam logic [1:0]  STATUS_RESET = 2'b10;
  localparam logic [15:0] REPLY_IDLE   = 16'hFFFF;

  // Beat widths
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 56;

  typedef struct packed {
    logic        mode;
    logic [9:0]  reg_offset;
    logic [2:0]  access_size;
    logic [31:0] write_data;
    logic        clock_enabled;
    logic [15:0] partner_reply;
  } item_t;

  typedef struct packed {
    logic        access_ok;
    logic [31:0] read_data;
    logic        frame_valid;
    logic [15:0] frame_out;
    logic        frame_is_wide;
    logic        irq_pending;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [31:0] control_one;
    logic [31:0] control_two;
    logic [1:0]  status_flags;
    logic [15:0] receive_data;
  } regs_t;

  // Interrupt line for a given register set and clock gate
  function automatic logic irq_calc(regs_t r, logic clk_on);
    logic rx_hit;
    logic tx_hit;
    rx_hit = r.control_two[RX_IE_BIT] && r.status_flags[FLAG_RX_FULL];
    tx_hit = r.control_two[TX_IE_BIT] && r.status_flags[FLAG_TX_EMPTY];
    return clk_on && r.control_one[ENABLE_BIT] && (rx_hit || tx_hit);
  endfunction

endpackage

FILE: rtl/spi_master_register_block.sv
// Channel      Dir  Handshake                       Payload
// s_axis       in   s_axis_tvalid / s_axis_tready   tdata: access fields, tuser: mode
// m_axis       out  m_axis_tvalid / m_axis_tready   tdata: result fields, tuser, tlast
// cfg          in   cfg_wen                         cfg_wdata: partner_attached
//
// Each access passes through the input register and then the output
// register; a new beat is taken every cycle while the output drains.
// A narrow-mode half or word data write holds the input register to emit its
// second frame beat. rst is synchronous: registers return to reset values
// (status shows transmit empty), partner_attached clears. An output stall
// holds the output register and then the input register in place.
module spi_master_register_block import smrb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // reg_offset[9:0], access_size[12:10], write_data[44:13], clock_enabled[45],
  // partner_reply[61:46], zero pad[63:62]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // mode[0]
  input  logic [0:0]             s_axis_tuser,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // access_ok[0], read_data[32:1], frame_valid[33], frame_out[49:34],
  // irq_pending[50], zero pad[55:51]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // frame_is_wide[0]
  output logic [0:0]             m_axis_tuser,
  output logic                   m_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic                   cfg_wen,
  input  logic                   cfg_wdata
);

  logic    partner_attached;
  regs_t   regs;
  regs_t   regs_next;
  logic    a_valid;
  logic    a_second;
  item_t   a_item;
  item_t   in_item;
  result_t res;
  result_t m_res;
  logic    two_frames;
  logic    out_free;
  logic    fire;
  logic    a_done;

  // Unpack the input beat
  assign in_item.mode          = s_axis_tuser[0];
  assign in_item.reg_offset    = s_axis_tdata[9:0];
  assign in_item.access_size   = s_axis_tdata[12:10];
  assign in_item.write_data    = s_axis_tdata[44:13];
  assign in_item.clock_enabled = s_axis_tdata[45];
  assign in_item.partner_reply = s_axis_tdata[61:46];

  smrb_access u_access (
    .item             (a_item),
    .second           (a_second),
    .regs             (regs),
    .partner_attached (partner_attached),
    .result           (res),
    .regs_next        (regs_next),
    .two_frames       (two_frames)
  );

  // Handshake control
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign fire          = a_valid && out_free;
  assign a_done        = fire && !two_frames;
  assign s_axis_tready = !a_valid || a_done;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      partner_attached <= 1'b0;
    end else if (cfg_wen) begin
      partner_attached <= cfg_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      a_second <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        a_valid <= s_axis_tvalid;
      end
      if (fire) begin
        a_second <= two_frames;
      end
    end
    if (s_axis_tready && s_axis_tvalid) begin
      a_item <= in_item;
    end
  end

  // Register file and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.control_one  <= '0;
      regs.control_two  <= '0;
      regs.status_flags <= STATUS_RESET;
      regs.receive_data <= '0;
      m_axis_tvalid     <= 1'b0;
    end else begin
      if (fire) begin
        regs <= regs_next;
      end
      if (out_free) begin
        m_axis_tvalid <= fire;
      end
    end
    if (fire) begin
      m_res <= res;
    end
  end

  // Pack the output beat
  assign m_axis_tdata = {5'd0, m_res.irq_pending, m_res.frame_out, m_res.frame_valid,
                         m_res.read_data, m_res.access_ok};
  assign m_axis_tuser = m_res.frame_is_wide;
  assign m_axis_tlast = m_res.last;

  // A second frame is only pending while its access is still held
  a_second_held: assert property (@(posedge clk) disable iff (rst)
    a_second |-> a_valid)
    else $error("second frame pending without a held access");

  // The second byte frame follows its first beat at once
  second_follows: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (m_axis_tvalid && m_axis_tdata[33]))
    else $error("second frame beat missing");

  // Transmit empty never drops
  tx_empty_set: assert property (@(posedge clk) disable iff (rst)
    regs.status_flags[FLAG_TX_EMPTY])
    else $error("transmit empty flag cleared");

  // Input stalls only while an access is held
  stall_held: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> a_valid)
    else $error("input stalled while empty");

endmodule

FILE: rtl/smrb_access.sv
module smrb_access import smrb_pkg::*; (
  input  item_t   item,
  input  logic    second,
  input  regs_t   regs,
  input  logic    partner_attached,
  output result_t result,
  output regs_t   regs_next,
  output logic    two_frames
);

  logic        size_ok;
  logic        off_ok;
  logic [31:0] rd;
  logic [15:0] reply;

  // Decode the access
  assign size_ok = (item.access_size == SIZE_BYTE) || (item.access_size == SIZE_HALF) ||
                   (item.access_size == SIZE_WORD);
  assign off_ok  = (item.reg_offset == OFF_CTRL1) || (item.reg_offset == OFF_CTRL2) ||
                   (item.reg_offset == OFF_STATUS) || (item.reg_offset == OFF_DATA);
  assign reply   = partner_attached ? item.partner_reply : REPLY_IDLE;

  // Apply the access to the registers and build the result beat
  always_comb begin
    result     = '0;
    result.last = 1'b1;
    regs_next  = regs;
    two_frames = 1'b0;
    rd         = '0;
    if (second) begin
      // second byte frame: state was updated with the first one
      result.access_ok   = 1'b1;
      result.frame_valid = 1'b1;
      result.frame_out   = {8'h00, item.write_data[15:8]};
      result.irq_pending = irq_calc(regs, 1'b1);
    end else if (!size_ok) begin
      result.irq_pending = irq_calc(regs, item.clock_enabled);
    end else if (!item.clock_enabled) begin
      result.access_ok = 1'b1;
    end else if (!off_ok) begin
      result.irq_pending = irq_calc(regs, 1'b1);
    end else if (item.mode == MODE_READ) begin
      result.access_ok = 1'b1;
      unique case (item.reg_offset)
        OFF_CTRL1:  rd = regs.control_one;
        OFF_CTRL2:  rd = regs.control_two;
        OFF_STATUS: rd = {30'd0, regs.status_flags};
        OFF_DATA: begin
          rd = {16'd0, regs.receive_data};
          regs_next.status_flags[FLAG_RX_FULL] = 1'b0;
        end
        default: rd = '0;
      endcase
      // mask to the access size; a word access keeps every bit
      if (item.access_size == SIZE_BYTE) begin
        rd = {24'd0, rd[7:0]};
      end else if (item.access_size == SIZE_HALF) begin
        rd = {16'd0, rd[15:0]};
      end
      result.read_data   = rd;
      result.irq_pending = irq_calc(regs_next, 1'b1);
    end else begin
      result.access_ok = 1'b1;
      unique case (item.reg_offset)
        OFF_CTRL1:  regs_next.control_one = item.write_data;
        OFF_CTRL2:  regs_next.control_two = item.write_data;
        OFF_STATUS: regs_next.status_flags =
                      (regs.status_flags & item.write_data[1:0]) | STATUS_RESET;
        OFF_DATA: begin
          if (regs.control_one[ENABLE_BIT]) begin
            regs_next.status_flags = 2'b11;
            result.frame_valid     = 1'b1;
            if (regs.control_one[WIDE_BIT]) begin
              regs_next.receive_data = reply;
              result.frame_out       = item.write_data[15:0];
              result.frame_is_wide   = 1'b1;
            end else if (item.access_size == SIZE_BYTE) begin
              regs_next.receive_data = {8'h00, reply[7:0]};
              result.frame_out       = {8'h00, item.write_data[7:0]};
            end else begin
              regs_next.receive_data = reply;
              result.frame_out       = {8'h00, item.write_data[7:0]};
              result.last            = 1'b0;
              two_frames             = 1'b1;
            end
          end
        end
        default: regs_next = regs;
      endcase
      result.irq_pending = irq_calc(regs_next, 1'b1);
    end
  end

endmodule
